[rtl/core/ole_pkg.sv]
`default_nettype none

package ole_pkg;

    localparam int MODE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_DEL_FRONT = 3'd1,
        MODE_DEL_END   = 3'd2,
        MODE_DEL_POS   = 3'd3,
        MODE_DEL_KEY   = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NOT_POSSIBLE = 2'd1,
        ST_NOT_FOUND    = 2'd2,
        ST_FULL         = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_TAKE,
        S_SHIFT,
        S_RESULT
    } t_state;

    // walk index source
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_END,
        IDX_POS,
        IDX_INC
    } t_idx_sel;

    typedef struct packed {
        logic     capture;     // latch request fields
        logic     ins_write;   // write value in front of head
        logic     head_inc;
        logic     count_dec;
        t_idx_sel idx_sel;
        logic     rd_ahead;    // read one past the next index
        logic     take;        // removed value <= read data
        logic     shift_write; // move read data down one slot
        logic     set_status;
        t_status  status_code;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  pos_ok;
        logic  key_hit;
        logic  idx_zero;
        logic  idx_last;
        logic  shift_last;
        logic  out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/core/ole_ctrl.sv]
`default_nettype none

module ole_ctrl
    import ole_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.mode)
                    MODE_DEL_FRONT, MODE_DEL_END: begin
                        n_state = i_stat.empty ? S_RESULT : S_TAKE;
                    end
                    MODE_DEL_POS: begin
                        n_state = i_stat.pos_ok ? S_TAKE : S_RESULT;
                    end
                    MODE_DEL_KEY: begin
                        n_state = i_stat.empty ? S_RESULT : S_SEARCH;
                    end
                    default: begin
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_SEARCH: begin
                if (i_stat.key_hit) begin
                    n_state = (i_stat.idx_zero || i_stat.idx_last) ? S_RESULT : S_SHIFT;
                end else if (i_stat.idx_last) begin
                    n_state = S_RESULT;
                end
            end
            S_TAKE: begin
                n_state = (i_stat.idx_zero || i_stat.idx_last) ? S_RESULT : S_SHIFT;
            end
            S_SHIFT: begin
                if (i_stat.shift_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd             = '0;
        o_cmd.idx_sel     = IDX_HOLD;
        o_cmd.status_code = ST_NOT_POSSIBLE;
        o_in_stall        = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                case (i_stat.mode)
                    MODE_INS_FRONT: begin
                        if (i_stat.full) begin
                            o_cmd.status_code = ST_FULL;
                        end else begin
                            o_cmd.status_code = ST_OK;
                            o_cmd.ins_write   = 1'b1;
                        end
                    end
                    MODE_DEL_FRONT, MODE_DEL_KEY: begin
                        o_cmd.idx_sel = IDX_ZERO;
                    end
                    MODE_DEL_END: begin
                        o_cmd.idx_sel = IDX_END;
                    end
                    MODE_DEL_POS: begin
                        o_cmd.idx_sel = IDX_POS;
                    end
                    default: begin
                        o_cmd.idx_sel = IDX_HOLD;
                    end
                endcase
            end
            S_SEARCH, S_TAKE: begin
                if (r_state == S_TAKE || i_stat.key_hit) begin
                    o_cmd.take        = 1'b1;
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_OK;
                    if (i_stat.idx_zero) begin
                        o_cmd.head_inc  = 1'b1;
                        o_cmd.count_dec = 1'b1;
                    end else if (i_stat.idx_last) begin
                        o_cmd.count_dec = 1'b1;
                    end else begin
                        o_cmd.rd_ahead = 1'b1;
                    end
                end else if (i_stat.idx_last) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_NOT_FOUND;
                end else begin
                    o_cmd.idx_sel = IDX_INC;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_write = 1'b1;
                if (i_stat.shift_last) begin
                    o_cmd.count_dec = 1'b1;
                end else begin
                    o_cmd.idx_sel  = IDX_INC;
                    o_cmd.rd_ahead = 1'b1;
                end
            end
            S_RESULT: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd.load_out = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/ole_dpath.sv]
`default_nettype none

module ole_dpath
    import ole_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output t_dp_stat                      o_stat,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    input  wire logic [POS_W-1:0]         i_position,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [DATA_W-1:0]      o_removed_value,
    output logic [LEN_W-1:0]              o_length
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [SW-1:0] j);
        logic [SW:0] sum;
        sum = (SW+1)'(head) + (SW+1)'(j);
        if (sum >= (SW+1)'(CAPACITY)) begin
            sum = sum - (SW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    logic [DATA_W-1:0]          mem [CAPACITY];
    logic [DATA_W-1:0]          r_rdata;
    logic [AW-1:0]              r_head;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              r_idx;
    logic [CW-1:0]              n_idx;
    t_mode                      r_mode;
    logic [DATA_W-1:0]          r_val;
    logic [POS_W-1:0]           r_pos;
    logic signed [DATA_W-1:0]   r_removed;
    t_status                    r_res_status;
    logic                       r_out_valid;
    logic [STATUS_W-1:0]        r_out_status;
    logic signed [DATA_W-1:0]   r_out_removed;
    logic [LEN_W-1:0]           r_out_length;

    logic [AW-1:0]              w_head_m1;
    logic [AW-1:0]              w_head_p1;
    logic [AW-1:0]              w_rd_addr;
    logic [AW-1:0]              w_wr_addr;
    logic [POS_W-1:0]           w_pos_m1;

    assign w_head_m1 = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign w_head_p1 = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
    assign w_pos_m1  = r_pos - POS_W'(1);

    always_comb begin
        case (i_cmd.idx_sel)
            IDX_ZERO: n_idx = '0;
            IDX_END:  n_idx = r_count - CW'(1);
            IDX_POS:  n_idx = CW'(w_pos_m1);
            IDX_INC:  n_idx = r_idx + CW'(1);
            default:  n_idx = r_idx;
        endcase
    end

    assign w_rd_addr = f_phys(r_head, SW'(n_idx) + SW'(i_cmd.rd_ahead));
    assign w_wr_addr = i_cmd.ins_write ? w_head_m1 : f_phys(r_head, SW'(r_idx));

    // list storage, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            mem[w_wr_addr] <= r_val;
        end else if (i_cmd.shift_write) begin
            mem[w_wr_addr] <= r_rdata;
        end
        r_rdata <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_write) begin
                r_head  <= w_head_m1;
                r_count <= r_count + CW'(1);
            end else begin
                if (i_cmd.head_inc) begin
                    r_head <= w_head_p1;
                end
                if (i_cmd.count_dec) begin
                    r_count <= r_count - CW'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.capture) begin
            r_mode    <= t_mode'(i_mode);
            r_val     <= i_item_value;
            r_pos     <= i_position;
            r_removed <= '0;
        end else if (i_cmd.take) begin
            r_removed <= r_rdata;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status_code;
        end
        if (i_cmd.load_out) begin
            r_out_status  <= r_res_status;
            r_out_removed <= r_removed;
            r_out_length  <= LEN_W'(r_count);
        end
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.full       = (r_count == CW'(CAPACITY));
        o_stat.empty      = (r_count == '0);
        o_stat.pos_ok     = (r_pos != '0) && (PW'(r_pos) <= PW'(r_count));
        o_stat.key_hit    = (r_rdata == r_val);
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.idx_last   = ((SW'(r_idx) + SW'(1)) == SW'(r_count));
        o_stat.shift_last = ((SW'(r_idx) + SW'(2)) == SW'(r_count));
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_value = r_out_removed;
    assign o_length        = r_out_length;

endmodule

`default_nettype wire

[rtl/core/ordered_list_engine.sv]
// Ordered list engine: a list of up to CAPACITY signed 32-bit values, front first.
// Input channel (i_in_valid / o_in_stall): one request item per handshake with
// i_mode (insert front, delete front, delete end, delete position, delete key),
// i_item_value (value or key) and i_position (1-based, delete position only).
// Output channel (o_out_valid / i_out_stall): one result item per request with
// o_status, o_removed_value and o_length (list length after the request).
// Items are handled one at a time. An insert, or a request refused as full or not
// possible, goes straight from decode to the result; delete front and delete end
// take the entry directly. Position and key deletes walk the list one entry a cycle
// through the storage's one read and one write port: a key delete searches to the
// match (a missing key ends the search at the last entry), then, unless the removed
// entry was first or last, the tail slides down one slot.
// The next item is taken in the cycle after the result is loaded, even while that
// result still waits in the output register; a stalled result holds its value
// and a finished item waits in its last state until the output register frees.
// Reset (synchronous, active low) empties the list and drops any pending result;
// storage itself is not cleared since only entries below the length are read.
`default_nettype none

module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    input  wire logic [POS_W-1:0]         i_position,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [DATA_W-1:0]      o_removed_value,
    output logic [LEN_W-1:0]              o_length
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: decode, search walk, tail slide, result handoff
    ole_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // circular buffer storage, head/length, walk index, output register
    ole_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_mode          (i_mode),
        .i_item_value    (i_item_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_length        (o_length)
    );

endmodule

`default_nettype wire
